FILE: rtl/sat_pkg.sv
`default_nettype none

package sat_pkg;

  localparam int AddrW       = 64;
  localparam int SectW       = 32;
  localparam int IdxW        = 4;
  localparam int CountW      = 5;
  localparam int MaxSections = 16;
  localparam int InDataW     = 200;
  localparam int PaddrW      = 4;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_V2F   = 2'd1,
    FUNC_F2V   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [0:0] {
    REG_IMAGE_BASE    = 1'b0,
    REG_SECTION_COUNT = 1'b1
  } reg_e;

  // For a write request, key carries {vaddr, vsize} and res carries {raw_ptr, raw_size}.
  typedef struct packed {
    logic             valid;
    func_e            func;
    logic [IdxW-1:0]  idx;
    logic             done;
    logic             hit;
    logic [AddrW-1:0] key;
    logic [AddrW-1:0] res;
  } token_t;

endpackage

`default_nettype wire

FILE: rtl/sat_cell.sv
`default_nettype none

module sat_cell #(
  parameter int Index = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          advance_i,
  input  wire logic [sat_pkg::CountW-1:0]    section_count_i,
  input  wire sat_pkg::token_t               tok_i,
  output sat_pkg::token_t                    tok_o
);

  logic [sat_pkg::SectW-1:0] vaddr_q, vsize_q, rawptr_q, rawsize_q;
  logic [sat_pkg::SectW-1:0] span, lo, off;
  logic [sat_pkg::AddrW:0]   diff;
  logic                      active, lookup, match, wr_here;
  sat_pkg::token_t           tok_d, tok_q;

  assign span   = (vsize_q < rawsize_q) ? vsize_q : rawsize_q;
  assign active = 32'(section_count_i) > 32'(Index);
  assign lookup = (tok_i.func == sat_pkg::FUNC_V2F) || (tok_i.func == sat_pkg::FUNC_F2V);
  assign lo     = (tok_i.func == sat_pkg::FUNC_V2F) ? vaddr_q : rawptr_q;
  assign off    = (tok_i.func == sat_pkg::FUNC_V2F) ? rawptr_q : vaddr_q;
  assign diff   = {1'b0, tok_i.key} - {{(sat_pkg::AddrW - sat_pkg::SectW + 1){1'b0}}, lo};
  assign match  = active && lookup && !tok_i.done && !diff[sat_pkg::AddrW]
                  && (diff[sat_pkg::AddrW-1:0]
                      < {{(sat_pkg::AddrW - sat_pkg::SectW){1'b0}}, span});
  assign wr_here = tok_i.valid && (tok_i.func == sat_pkg::FUNC_WRITE)
                   && (32'(tok_i.idx) == 32'(Index));

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.done = 1'b1;
      tok_d.hit  = 1'b1;
      tok_d.res  = {{(sat_pkg::AddrW - sat_pkg::SectW){1'b0}}, off}
                   + diff[sat_pkg::AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && wr_here) begin
      vaddr_q   <= tok_i.key[sat_pkg::AddrW-1:sat_pkg::SectW];
      vsize_q   <= tok_i.key[sat_pkg::SectW-1:0];
      rawptr_q  <= tok_i.res[sat_pkg::AddrW-1:sat_pkg::SectW];
      rawsize_q <= tok_i.res[sat_pkg::SectW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (advance_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

FILE: rtl/section_address_translator.sv
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   func, index, query, entry fields
// m_axis    out        m_axis_tvalid / m_axis_tready   mapped address, hit flag
// apb       in         psel, penable / pready          image_base, section_count
//
// One request is accepted per cycle unless the output stalls; each result passes the
// head register, one section cell per table entry, and the output register.
// Reset clears the configuration registers, the output valid flag and the request valid flags.
// When the output is stalled the whole row holds, and s_axis_tready falls.
`default_nettype none

module section_address_translator #(
  parameter int MAX_SECTIONS = sat_pkg::MaxSections
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // func[1:0], entry_index[5:2], query_address[69:6], entry_vaddr[101:70],
  // entry_vsize[133:102], entry_raw_ptr[165:134], entry_raw_size[197:166]
  input  wire logic [sat_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // mapped_address[63:0]
  output logic [sat_pkg::AddrW-1:0]         m_axis_tdata,
  // hit[0]
  output logic                              m_axis_tuser,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sat_pkg::PaddrW-1:0]   paddr,
  input  wire logic [sat_pkg::AddrW-1:0]    pwdata,
  output logic [sat_pkg::AddrW-1:0]         prdata,
  output logic                              pready
);

  logic [sat_pkg::AddrW-1:0]  image_base_q;
  logic [sat_pkg::CountW-1:0] section_count_q;
  logic                       cfg_wr, advance;
  sat_pkg::reg_e              reg_sel;

  sat_pkg::func_e             in_func;
  logic [sat_pkg::AddrW-1:0]  in_query;
  sat_pkg::token_t            head_d, head_q;
  sat_pkg::token_t            chain [MAX_SECTIONS+1];

  logic                       out_valid_q;
  logic [sat_pkg::AddrW-1:0]  out_data_q, out_data_d;
  logic                       out_hit_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = sat_pkg::reg_e'(paddr[3]);

  always_comb begin
    unique case (reg_sel)
      sat_pkg::REG_IMAGE_BASE:    prdata = image_base_q;
      sat_pkg::REG_SECTION_COUNT: prdata = {{(sat_pkg::AddrW - sat_pkg::CountW){1'b0}},
                                            section_count_q};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_base_q    <= '0;
      section_count_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        sat_pkg::REG_IMAGE_BASE:    image_base_q    <= pwdata;
        sat_pkg::REG_SECTION_COUNT: section_count_q <= pwdata[sat_pkg::CountW-1:0];
        default:                    ;
      endcase
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  assign in_func  = sat_pkg::func_e'(s_axis_tdata[1:0]);
  assign in_query = s_axis_tdata[69:6];

  always_comb begin
    head_d       = '0;
    head_d.valid = s_axis_tvalid;
    head_d.func  = in_func;
    head_d.idx   = s_axis_tdata[5:2];
    head_d.done  = 1'b1;
    case (in_func)
      sat_pkg::FUNC_WRITE: begin
        head_d.key = {s_axis_tdata[101:70], s_axis_tdata[133:102]};
        head_d.res = {s_axis_tdata[165:134], s_axis_tdata[197:166]};
      end
      sat_pkg::FUNC_V2F: begin
        head_d.key  = in_query - image_base_q;
        head_d.done = in_query < image_base_q;
      end
      sat_pkg::FUNC_F2V: begin
        head_d.key  = in_query;
        head_d.done = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (advance) begin
      head_q <= head_d;
    end
  end

  assign chain[0] = head_q;

  for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
    sat_cell #(
      .Index(i)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .advance_i      (advance),
      .section_count_i(section_count_q),
      .tok_i          (chain[i]),
      .tok_o          (chain[i+1])
    );
  end

  always_comb begin
    out_data_d = '0;
    if (chain[MAX_SECTIONS].hit) begin
      out_data_d = (chain[MAX_SECTIONS].func == sat_pkg::FUNC_F2V)
                   ? chain[MAX_SECTIONS].res + image_base_q
                   : chain[MAX_SECTIONS].res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= chain[MAX_SECTIONS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
      out_hit_q  <= chain[MAX_SECTIONS].hit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_hit_q;

endmodule

`default_nettype wire
